// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the keyed counter table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define KCT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kct assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define KCT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("kct forbidden condition seen");
`else
`define KCT_ASSERT(label, clk, rst, prop)
`define KCT_NEVER(label, clk, rst, cond)
`endif

`endif

// File: hw/rtl/kct_pkg.sv
// Types and constants shared by the keyed counter table modules.
`timescale 1ns / 1ps

package kct_pkg;

   localparam int KCT_ENTRIES   = 64;
   localparam int KEY_WIDTH     = 16;
   localparam int COUNT_WIDTH   = 32;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_COST  = 2'd1,
      ACT_SET   = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      action_type             action;
      logic [KEY_WIDTH-1:0]   item_key;
      logic [COUNT_WIDTH-1:0] amount;
   } kct_req_type;

   typedef struct packed {
      status_type             status;
      logic [COUNT_WIDTH-1:0] count_now;
      logic                   enough;
      logic                   changed;
   } kct_rsp_type;

   // Per-cell write controls; at most one is set in a cycle.
   typedef struct packed {
      logic wr_count;
      logic take_next;
      logic load_new;
   } cell_ctl_type;

endpackage

// File: hw/rtl/kct_cell.sv
// One table cell: holds a key and its count, compares against the request key.
`timescale 1ns / 1ps

module kct_cell
   import kct_pkg::*;
(
   input  logic                   clock,
   input  cell_ctl_type           ctl,
   input  logic                   live,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [KEY_WIDTH-1:0]   new_key,
   input  logic [COUNT_WIDTH-1:0] new_count,
   input  logic [KEY_WIDTH-1:0]   next_key,
   input  logic [COUNT_WIDTH-1:0] next_count,
   output logic [KEY_WIDTH-1:0]   key,
   output logic [COUNT_WIDTH-1:0] count,
   output logic                   match
);

   logic [KEY_WIDTH-1:0]   key_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   // A removal shifts the neighbor's entry in, compacting the live region.
   always_ff @(posedge clock) begin
      if (ctl.load_new) begin
         key_ff   <= new_key;
         count_ff <= new_count;
      end else if (ctl.take_next) begin
         key_ff   <= next_key;
         count_ff <= next_count;
      end else if (ctl.wr_count) begin
         count_ff <= new_count;
      end
   end

   assign key   = key_ff;
   assign count = count_ff;
   assign match = live && (key_ff == req_key);

endmodule

// File: hw/rtl/kct_select.sv
// One-hot selection of the matching cell's count and index.
`timescale 1ns / 1ps

module kct_select
   import kct_pkg::*;
#(
   parameter int ENTRIES = KCT_ENTRIES,
   parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
   input  logic [ENTRIES-1:0]     match,
   input  logic [COUNT_WIDTH-1:0] counts [ENTRIES],
   output logic                   hit,
   output logic [COUNT_WIDTH-1:0] count,
   output logic [IW-1:0]          slot
);

   // Keys are unique among live cells, so at most one match bit is set.
   always_comb begin
      hit   = 1'b0;
      count = '0;
      slot  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit   = hit | match[i];
         count = count | (match[i] ? counts[i] : '0);
         slot  = slot | (match[i] ? IW'(i) : '0);
      end
   end

endmodule

// File: hw/rtl/keyed_counter_table.sv
// Top level of the keyed counter table: control, update arithmetic and the cell row.
// An accepted request passes through the lookup and apply states; its result is then registered and strobed.
// A new request may be accepted in the apply cycle of the one before; busy is high only in the lookup cycle.
// The lookup cycle compares all cells at once; the apply cycle updates, inserts or removes one entry.
// Reset empties the table by clearing the entry count; cell contents are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_counter_table
   import kct_pkg::*;
#(
   parameter int ENTRIES = KCT_ENTRIES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  kct_req_type req_payload,
   output logic        busy,
   output logic        rsp_valid,
   output kct_rsp_type rsp_payload
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UW = $clog2(ENTRIES + 1);

   // The sequencer walks idle, lookup and apply. A new request may be taken
   // in the apply cycle, because the cells update at the same edge that the
   // following lookup begins after.
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_APPLY
   } state_type;

   state_type              state_ff, state_in;
   kct_req_type            req_ff;
   logic                   hit_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [IW-1:0]          slot_ff;
   logic [UW-1:0]          used_ff, used_in;
   logic                   rsp_valid_ff;
   kct_rsp_type            rsp_ff, rsp_in;

   logic                   accept;
   logic                   in_apply;
   logic                   sel_hit;
   logic [COUNT_WIDTH-1:0] sel_count;
   logic [IW-1:0]          sel_slot;

   logic [ENTRIES-1:0]     match_w;
   logic [ENTRIES-1:0]     live_w;
   logic [KEY_WIDTH-1:0]   key_w   [ENTRIES];
   logic [COUNT_WIDTH-1:0] count_w [ENTRIES];
   cell_ctl_type           ctl_w   [ENTRIES];

   logic                   do_upd, do_rem, do_ins;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [COUNT_WIDTH:0]   sum_wide;
   logic [COUNT_WIDTH-1:0] add_val;
   logic [COUNT_WIDTH-1:0] diff;
   logic                   covers;
   logic                   full;

   assign busy     = (state_ff == S_LOOK);
   assign accept   = start && !busy;
   assign in_apply = (state_ff == S_APPLY);

   // The cell row. Each cell sees its right-hand neighbor so that removing
   // an entry shifts every later live entry one place toward index zero.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   nxt_key;
      logic [COUNT_WIDTH-1:0] nxt_count;

      if (i == ENTRIES - 1) begin : g_end
         assign nxt_key   = '0;
         assign nxt_count = '0;
      end else begin : g_mid
         assign nxt_key   = key_w[i+1];
         assign nxt_count = count_w[i+1];
      end

      assign live_w[i] = (UW'(i) < used_ff);

      assign ctl_w[i].wr_count  = in_apply && do_upd && (IW'(i) == slot_ff);
      assign ctl_w[i].take_next = in_apply && do_rem && (IW'(i) >= slot_ff)
                                  && (UW'(i + 1) < used_ff);
      assign ctl_w[i].load_new  = in_apply && do_ins && (UW'(i) == used_ff);

      kct_cell u_cell (
         .clock      (clock),
         .ctl        (ctl_w[i]),
         .live       (live_w[i]),
         .req_key    (req_ff.item_key),
         .new_key    (req_ff.item_key),
         .new_count  (new_count),
         .next_key   (nxt_key),
         .next_count (nxt_count),
         .key        (key_w[i]),
         .count      (count_w[i]),
         .match      (match_w[i])
      );
   end

   kct_select #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_select (
      .match  (match_w),
      .counts (count_w),
      .hit    (sel_hit),
      .count  (sel_count),
      .slot   (sel_slot)
   );

   // Update arithmetic for the apply cycle, working from the registered lookup.
   assign sum_wide = {1'b0, cnt_ff} + {1'b0, req_ff.amount};
   assign add_val  = sum_wide[COUNT_WIDTH] ? '1 : sum_wide[COUNT_WIDTH-1:0];
   assign diff     = cnt_ff - req_ff.amount;
   assign covers   = (cnt_ff <= req_ff.amount);
   assign full     = (used_ff == UW'(ENTRIES));

   always_comb begin
      do_upd    = 1'b0;
      do_rem    = 1'b0;
      do_ins    = 1'b0;
      new_count = req_ff.amount;
      rsp_in    = '{status: ST_OK, count_now: '0, enough: 1'b0, changed: 1'b0};
      case (req_ff.action)
         ACT_ADD, ACT_SET: begin
            if (hit_ff) begin
               do_upd    = 1'b1;
               new_count = (req_ff.action == ACT_ADD) ? add_val : req_ff.amount;
               rsp_in.count_now = new_count;
               rsp_in.changed   = 1'b1;
            end else if (!full) begin
               do_ins           = 1'b1;
               rsp_in.count_now = req_ff.amount;
               rsp_in.changed   = 1'b1;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         ACT_COST: begin
            if (!hit_ff) begin
               rsp_in.status = ST_MISSING;
            end else if (covers) begin
               // The entry is spent and leaves the table.
               do_rem         = 1'b1;
               rsp_in.changed = 1'b1;
            end else begin
               do_upd           = 1'b1;
               new_count        = diff;
               rsp_in.count_now = diff;
               rsp_in.changed   = 1'b1;
            end
         end
         ACT_QUERY: begin
            rsp_in.count_now = hit_ff ? cnt_ff : '0;
            rsp_in.status    = hit_ff ? ST_OK : ST_MISSING;
            rsp_in.enough    = (req_ff.amount == '0) || (hit_ff && !covers)
                               || (hit_ff && (cnt_ff == req_ff.amount));
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      used_in = used_ff;
      if (in_apply && do_rem) begin
         used_in = used_ff - UW'(1);
      end else if (in_apply && do_ins) begin
         used_in = used_ff + UW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  state_in = accept ? S_LOOK : S_IDLE;
         S_LOOK:  state_in = S_APPLY;
         S_APPLY: state_in = accept ? S_LOOK : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer state, the request and lookup registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= in_apply;
      end
      if (accept) begin
         req_ff <= req_payload;
      end
      if (state_ff == S_LOOK) begin
         hit_ff  <= sel_hit;
         cnt_ff  <= sel_count;
         slot_ff <= sel_slot;
      end
      if (in_apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A result appears only in the cycle after an apply cycle.
   `KCT_ASSERT(a_rsp_after_apply, clock, reset, rsp_valid |-> $past(state_ff == S_APPLY))
   // The entry count never exceeds the table size.
   `KCT_ASSERT(a_used_bound, clock, reset, used_ff <= UW'(ENTRIES))
   // Every accepted request is looked up in the following cycle.
   `KCT_ASSERT(a_accept_look, clock, reset, accept |=> (state_ff == S_LOOK))
   // A removal shrinks the table by exactly one entry.
   `KCT_ASSERT(a_rem_shrinks, clock, reset,
      (in_apply && do_rem) |=> (used_ff == $past(used_ff) - UW'(1)))
   // A hit implies a non-empty table.
   `KCT_NEVER(a_hit_empty, clock, reset, in_apply && hit_ff && (used_ff == '0))

endmodule

// File: tb/sv/keyed_counter_table_tb.sv
// Self-checking testbench for the keyed counter table.
`timescale 1ns / 1ps

module keyed_counter_table_tb;
   import kct_pkg::*;

   // Upper bound on consecutive cycles in which neither a request nor a
   // result is accepted. The longest legal gap is the random idle gap before a
   // request plus the latency of its result, so this leaves a wide margin.
   localparam int STALL_LIMIT = 400;
   // Cycles to wait after the last result before the final verdict.
   localparam int DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        start;
   kct_req_type req_payload;
   logic        busy;
   logic        rsp_valid;
   kct_rsp_type rsp_payload;

   // Scoreboard: it mirrors the table contents, predicts the result of each
   // accepted request and checks the results in order of arrival.
   class count_table_scoreboard;
      logic [KEY_WIDTH-1:0]   mirror_keys[KCT_ENTRIES];
      logic [COUNT_WIDTH-1:0] mirror_counts[KCT_ENTRIES];
      int unsigned            live_entries;
      kct_rsp_type            expected_q[$];
      int unsigned            errors;
      int unsigned            requests_seen;
      int unsigned            results_seen;
      int unsigned            full_seen;
      int unsigned            missing_seen;
      int unsigned            removals_seen;
      int unsigned            saturated_seen;

      function new();
         live_entries   = 0;
         errors         = 0;
         requests_seen  = 0;
         results_seen   = 0;
         full_seen      = 0;
         missing_seen   = 0;
         removals_seen  = 0;
         saturated_seen = 0;
      endfunction

      // The lowest live slot holding the key wins; -1 when the key is absent.
      function int lookup_slot(logic [KEY_WIDTH-1:0] key);
         for (int i = 0; i < int'(live_entries); i++) begin
            if (mirror_keys[i] == key) return i;
         end
         return -1;
      endfunction

      function void note_request(kct_req_type r);
         kct_rsp_type          e;
         int                   slot;
         logic [COUNT_WIDTH:0] sum;
         int unsigned          last;
         e = '0;
         e.status = ST_OK;
         slot = lookup_slot(r.item_key);
         requests_seen++;
         case (r.action)
            ACT_ADD, ACT_SET: begin
               if (slot >= 0) begin
                  if (r.action == ACT_SET) begin
                     mirror_counts[slot] = r.amount;
                  end else begin
                     sum = {1'b0, mirror_counts[slot]} + {1'b0, r.amount};
                     if (sum[COUNT_WIDTH]) saturated_seen++;
                     mirror_counts[slot] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
                  end
                  e.count_now = mirror_counts[slot];
                  e.changed   = 1'b1;
               end else if (live_entries < KCT_ENTRIES) begin
                  mirror_keys[live_entries]   = r.item_key;
                  mirror_counts[live_entries] = r.amount;
                  live_entries++;
                  e.count_now = r.amount;
                  e.changed   = 1'b1;
               end else begin
                  e.status = ST_FULL;
                  full_seen++;
               end
            end
            ACT_COST: begin
               if (slot < 0) begin
                  e.status = ST_MISSING;
                  missing_seen++;
               end else if (mirror_counts[slot] <= r.amount) begin
                  // The entry goes away and the last live entry fills its slot.
                  last = live_entries - 1;
                  mirror_keys[slot]   = mirror_keys[last];
                  mirror_counts[slot] = mirror_counts[last];
                  live_entries = last;
                  e.changed = 1'b1;
                  removals_seen++;
               end else begin
                  mirror_counts[slot] = mirror_counts[slot] - r.amount;
                  e.count_now = mirror_counts[slot];
                  e.changed   = 1'b1;
               end
            end
            ACT_QUERY: begin
               if (slot >= 0) begin
                  e.count_now = mirror_counts[slot];
               end else begin
                  e.status = ST_MISSING;
                  missing_seen++;
               end
               e.enough = (r.amount == '0) || (slot >= 0 && e.count_now >= r.amount);
            end
            default: begin
               e.status = ST_OK;
            end
         endcase
         expected_q.push_back(e);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(kct_rsp_type got);
         kct_rsp_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding: %p", got));
         end else begin
            e = expected_q.pop_front();
            if (got.status !== e.status)
               report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.count_now !== e.count_now)
               report_mismatch($sformatf("count_now %h, expected %h",
                                         got.count_now, e.count_now));
            if (got.enough !== e.enough)
               report_mismatch($sformatf("enough %b, expected %b", got.enough, e.enough));
            if (got.changed !== e.changed)
               report_mismatch($sformatf("changed %b, expected %b",
                                         got.changed, e.changed));
         end
      endtask

      function int unsigned outstanding();
         return expected_q.size();
      endfunction
   endclass

   count_table_scoreboard scoreboard;
   logic [KEY_WIDTH-1:0]  key_pool[128];
   int unsigned           idle_cycles;
   bit                    no_idle_stretch;

   keyed_counter_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Monitor. All signals are sampled at the rising edge, so both the
   // request handshake and the result strobe are seen with their values
   // from the cycle that the edge ends.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) scoreboard.note_request(req_payload);
         if (rsp_valid) scoreboard.check_result(rsp_payload);
      end
   end

   // Watchdog: a hung handshake or a lost result stops the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic kct_req_type make_request(action_type act, logic [KEY_WIDTH-1:0] key,
                                                logic [COUNT_WIDTH-1:0] amt);
      kct_req_type r;
      r.action   = act;
      r.item_key = key;
      r.amount   = amt;
      return r;
   endfunction

   // Presents one request and returns at the edge that accepts it. Start
   // stays high afterwards so that a back-to-back request needs no glitch.
   task automatic send_request(kct_req_type r);
      int gap;
      if ($urandom_range(0, 31) == 0) no_idle_stretch = ~no_idle_stretch;
      gap = no_idle_stretch ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   // Holds the request side idle until every outstanding result is back.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (scoreboard.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [COUNT_WIDTH-1:0] pick_amount();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 1;
         2, 3:    return $urandom_range(1, 100);
         4:       return '1;
         5:       return 32'hFFFF_FFFF - $urandom_range(0, 100);
         default: return $urandom;
      endcase
   endfunction

   // A run of random requests. Keys come mostly from the first pool_span pool
   // entries so that hits, removals and a full table all happen; now and
   // then a key is drawn from the whole 16-bit range.
   task automatic random_phase(int items, int pool_span, int add_pct, int cost_pct,
                               int set_pct);
      int                   pick;
      action_type           act;
      logic [KEY_WIDTH-1:0] key;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < add_pct) act = ACT_ADD;
         else if (pick < add_pct + cost_pct) act = ACT_COST;
         else if (pick < add_pct + cost_pct + set_pct) act = ACT_SET;
         else act = ACT_QUERY;
         if ($urandom_range(0, 9) == 0) key = KEY_WIDTH'($urandom_range(0, 65535));
         else key = key_pool[7'($urandom_range(0, pool_span - 1))];
         send_request(make_request(act, key, pick_amount()));
      end
      wait_for_results();
   endtask

   initial begin
      scoreboard      = new();
      no_idle_stretch = 1'b0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      foreach (key_pool[i]) key_pool[i] = KEY_WIDTH'($urandom_range(0, 65535));
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: misses on an empty table, extreme keys and amounts,
      // saturation, removal at zero and removal that moves the last entry.
      send_request(make_request(ACT_QUERY, 16'h0000, 32'h0));        // absent, amount 0
      send_request(make_request(ACT_QUERY, 16'hFFFF, 32'd5));        // absent, not enough
      send_request(make_request(ACT_COST,  16'h8000, 32'd1));        // cost of absent key
      send_request(make_request(ACT_ADD,   16'h0000, 32'h0));        // insert with zero
      send_request(make_request(ACT_ADD,   16'hFFFF, 32'hFFFF_FFFF));
      send_request(make_request(ACT_ADD,   16'hFFFF, 32'd1));        // saturates
      send_request(make_request(ACT_QUERY, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(make_request(ACT_SET,   16'h0000, 32'd10));
      send_request(make_request(ACT_QUERY, 16'h0000, 32'd11));       // one short
      send_request(make_request(ACT_QUERY, 16'h0000, 32'd10));       // exactly enough
      send_request(make_request(ACT_ADD,   16'h1234, 32'h0));
      send_request(make_request(ACT_COST,  16'h1234, 32'h0));        // zero count removed
      send_request(make_request(ACT_SET,   16'h5555, 32'hAAAA_AAAA)); // set inserts
      send_request(make_request(ACT_SET,   16'hAAAA, 32'h5555_5555));
      send_request(make_request(ACT_COST,  16'h0000, 32'd3));
      send_request(make_request(ACT_COST,  16'h0000, 32'd7));        // last entry moves down
      send_request(make_request(ACT_QUERY, 16'hAAAA, 32'h0));
      send_request(make_request(ACT_ADD,   16'h5555, 32'h5555_5555)); // reaches max exactly
      send_request(make_request(ACT_COST,  16'h5555, 32'hFFFF_FFFE));
      send_request(make_request(ACT_COST,  16'hFFFF, 32'h0));        // cost of zero keeps entry
      send_request(make_request(ACT_QUERY, 16'h5555, 32'd2));
      send_request(make_request(ACT_SET,   16'hFFFF, 32'h0));
      send_request(make_request(ACT_QUERY, 16'hFFFF, 32'h0));
      wait_for_results();

      // Random part: churn on a few keys, then a wide key set that fills the
      // table and runs into the full case, then heavy cost traffic, then a
      // narrow mix again on what is left.
      random_phase(200, 24,  35, 20, 15);
      random_phase(250, 128, 50, 5,  25);
      random_phase(150, 128, 25, 40, 10);
      random_phase(150, 12,  30, 30, 15);

      repeat (DRAIN_CYCLES) @(posedge clock);
      while (scoreboard.outstanding() != 0) begin
         scoreboard.report_mismatch("request left without a result");
         void'(scoreboard.expected_q.pop_front());
      end

      $display("Ran %0d requests, checked %0d results.",
               scoreboard.requests_seen, scoreboard.results_seen);
      $display("Seen: %0d table full, %0d key missing, %0d removals, %0d saturating adds.",
               scoreboard.full_seen, scoreboard.missing_seen,
               scoreboard.removals_seen, scoreboard.saturated_seen);
      if (scoreboard.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/kct_pkg.sv
hw/rtl/kct_cell.sv
hw/rtl/kct_select.sv
hw/rtl/keyed_counter_table.sv
tb/sv/keyed_counter_table_tb.sv
